[rtl/idwt53_pkg.sv]
package idwt53_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int OUT_BITS    = SAMPLE_BITS + 2;
  localparam int ACC_BITS    = OUT_BITS + 2;
  localparam int POS_BITS    = 13;
  localparam int POS_WRAP_TO = 2;

  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // most samples one coefficient can release
  localparam int MAX_RES  = 3;
  localparam int NUM_BITS = 2;

  localparam int Q_DEPTH = 8;
  localparam int Q_PTR   = 3;
  localparam int Q_CNT   = Q_PTR + 1;

  typedef logic signed [SAMPLE_BITS-1:0] coef_t;
  typedef logic signed [OUT_BITS-1:0]    sample_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  typedef struct packed {
    logic    last;
    sample_t sample;
  } res_t;

  // sliding window and line position
  typedef struct packed {
    coef_t               w0;   // previous coefficient
    coef_t               w1;   // coefficient before that
    sample_t             w2;   // latest reconstructed lowpass
    logic [POS_BITS-1:0] pos;  // coefficients seen in this line
  } state_t;

  typedef struct packed {
    logic [NUM_BITS-1:0]     num;
    res_t [MAX_RES-1:0]      res;
    state_t                  nxt;
  } lift_out_t;

endpackage

[rtl/idwt53_lift.sv]
module idwt53_lift
  import idwt53_pkg::*;
(
  input  coef_t     coef_i,
  input  logic      last_i,
  input  logic      first_odd_i,
  input  state_t    state_i,
  output lift_out_t lift_o
);

  function automatic acc_t lift_low(acc_t xv, acc_t a, acc_t b);
    acc_t s;
    s = a + b + acc_t'(2);
    return xv - (s >>> 2);
  endfunction

  function automatic acc_t lift_high(acc_t xv, acc_t a, acc_t b);
    acc_t s;
    s = a + b;
    return xv + (s >>> 1);
  endfunction

  acc_t                x, w0, w1, w2;
  acc_t                left_h, ye_o, yl_o, hp_o, tail_o;
  acc_t                ye_e, yl_e, hp_e;
  logic                odd, pge1, pge2, pge3;
  logic [POS_BITS:0]   pos_inc;

  assign x  = acc_t'(coef_i);
  assign w0 = acc_t'($signed(state_i.w0));
  assign w1 = acc_t'($signed(state_i.w1));
  assign w2 = acc_t'($signed(state_i.w2));

  assign odd  = first_odd_i ^ state_i.pos[0];
  assign pge1 = (state_i.pos != '0);
  assign pge2 = (state_i.pos[POS_BITS-1:1] != '0);
  assign pge3 = pge2 && (state_i.pos != POS_BITS'(2));

  // highpass-indexed coefficient closes a lowpass and its left neighbor
  assign left_h = pge2 ? w1 : x;
  assign ye_o   = lift_low(w0, left_h, x);
  assign yl_o   = pge3 ? w2 : ye_o;
  assign hp_o   = lift_high(w1, yl_o, ye_o);
  assign tail_o = x + ye_o;

  // line ending on a lowpass index: mirrored right high is the left one
  assign ye_e = lift_low(x, w0, w0);
  assign yl_e = pge2 ? w2 : ye_e;
  assign hp_e = lift_high(w0, yl_e, ye_e);

  assign pos_inc = {1'b0, state_i.pos} + (POS_BITS+1)'(1);

  always_comb begin
    lift_o     = '0;
    lift_o.nxt = state_i;

    if (last_i && !pge1) begin
      lift_o.num           = NUM_BITS'(1);
      lift_o.res[0].sample = odd ? sample_t'(x >>> 1) : sample_t'(x);
      lift_o.res[0].last   = 1'b1;
    end else if (odd) begin
      if (pge1) begin
        lift_o.nxt.w2 = sample_t'(ye_o);
        if (pge2) begin
          lift_o.res[0].sample = sample_t'(hp_o);
          lift_o.res[1].sample = sample_t'(ye_o);
          lift_o.res[2].sample = sample_t'(tail_o);
          lift_o.res[2].last   = 1'b1;
          lift_o.num           = last_i ? NUM_BITS'(3) : NUM_BITS'(2);
        end else begin
          lift_o.res[0].sample = sample_t'(ye_o);
          lift_o.res[1].sample = sample_t'(tail_o);
          lift_o.res[1].last   = 1'b1;
          lift_o.num           = last_i ? NUM_BITS'(2) : NUM_BITS'(1);
        end
      end
    end else if (last_i) begin
      lift_o.res[0].sample = sample_t'(hp_e);
      lift_o.res[1].sample = sample_t'(ye_e);
      lift_o.res[1].last   = 1'b1;
      lift_o.num           = NUM_BITS'(2);
    end

    if (last_i) begin
      lift_o.nxt = '0;
    end else begin
      lift_o.nxt.w1 = state_i.w0;
      lift_o.nxt.w0 = coef_i;
      if (pos_inc[POS_BITS]) begin
        lift_o.nxt.pos = POS_BITS'(POS_WRAP_TO);
      end else begin
        lift_o.nxt.pos = pos_inc[POS_BITS-1:0];
      end
    end
  end

endmodule

[rtl/idwt53_outq.sv]
module idwt53_outq
  import idwt53_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [NUM_BITS-1:0] push_num_i,
  input  res_t [MAX_RES-1:0]  push_data_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output res_t                data_o
);

  res_t             mem_q [Q_DEPTH];
  logic [Q_PTR-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT-1:0] count_q, count_d;
  logic             pop;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;
  // leave space for a full burst of results
  assign room_o  = (count_q <= Q_CNT'(Q_DEPTH - MAX_RES));

  assign wr_ptr_d = wr_ptr_q + Q_PTR'(push_num_i);
  assign rd_ptr_d = rd_ptr_q + Q_PTR'(pop);
  assign count_d  = count_q + Q_CNT'(push_num_i) - Q_CNT'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (NUM_BITS'(k) < push_num_i) begin
        mem_q[wr_ptr_q + Q_PTR'(k)] <= push_data_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[rtl/inverse_dwt_53_reversible_lifting.sv]
// an accepted coefficient is held in the input register stage, its samples then in the result queue
// throughput: one coefficient per cycle while the queue has room; samples leave one per
//   ready cycle, one per coefficient over a line; the 8-entry queue takes bursts of up to 3
// reset (rst_ni low, asynchronous): window, line position, queue and register cleared
module inverse_dwt_53_reversible_lifting
  import idwt53_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write: bit 0 is first_index_odd
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i,
  // coefficient stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [23:0] coefficient
  input  logic                   s_axis_tlast,   // last_in_line
  // sample stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [25:0] sample, rest zero
  output logic                   m_axis_tlast    // last_of_line
);

  // parity of the first index of a line
  logic      first_odd_q;

  // input register stage
  logic      s1_valid_q, s1_valid_d;
  coef_t     s1_coef_q;
  logic      s1_last_q;

  // sliding window state, updated once per coefficient
  state_t    state_q;

  lift_out_t lift;
  logic      room;
  logic      advance;
  logic      in_req;
  res_t      head;

  assign cfg_ready_o = 1'b1;

  // the lifting stage retires its coefficient when the queue can take a full burst
  assign advance       = s1_valid_q && room;
  assign s_axis_tready = !s1_valid_q || room;
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign s1_valid_d    = in_req || (s1_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_odd_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      first_odd_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // payload of the input stage
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      s1_coef_q <= coef_t'(s_axis_tdata[SAMPLE_BITS-1:0]);
      s1_last_q <= s_axis_tlast;
    end
  end

  // window and position return to zero at the end of each line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= lift.nxt;
    end
  end

  // both lifting steps for one coefficient, plus next window
  idwt53_lift u_lift (
    .coef_i      (s1_coef_q),
    .last_i      (s1_last_q),
    .first_odd_i (first_odd_q),
    .state_i     (state_q),
    .lift_o      (lift)
  );

  // results of one coefficient enter the queue together, in index order
  idwt53_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_num_i  (advance ? lift.num : NUM_BITS'(0)),
    .push_data_i (lift.res),
    .room_o      (room),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (head)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, head.sample};
  assign m_axis_tlast = head.last;

endmodule
